[rtl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg - shared types and constants for the Stanley steering block
// Beat types, register and operation codes, CORDIC angle table and helpers.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int PATH_DEPTH_DEFAULT = 512;

    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_W     = 52;   // CORDIC x/y datapath width
    localparam int ANGLE_W      = 21;   // Q16 angle accumulator width

    localparam int PI_Q16     = 205887;
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;

    localparam logic [15:0] GAIN_K_RESET      = 16'd358;
    localparam logic [15:0] SOFT_SPEED_RESET  = 16'd128;
    localparam logic [13:0] STEER_LIMIT_RESET = 14'd4289;
    localparam logic [9:0]  PATH_COUNT_RESET  = 10'd400;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    localparam logic [1:0] CFG_GAIN_K      = 2'd0;
    localparam logic [1:0] CFG_SOFT_SPEED  = 2'd1;
    localparam logic [1:0] CFG_STEER_LIMIT = 2'd2;
    localparam logic [1:0] CFG_PATH_COUNT  = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [8:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] vehicle_x;
        logic signed [31:0] vehicle_y;
        logic signed [15:0] vehicle_heading;
        logic [15:0]        vehicle_speed;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] steer_angle;
        logic signed [31:0] cross_track_error;
        logic signed [15:0] heading_error;
        logic [8:0]         nearest_index;
    } res_item_t;

    // atan(2^-i) in Q16 radians
    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30385;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // magnitude of a 33-bit difference whose magnitude stays below 2^32
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] a;
        a = v[32] ? -v : v;
        return a[31:0];
    endfunction

endpackage

[rtl/spt_ram.sv]
// ----------------------------------------------------------------------------
// spt_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = spt_pkg::PATH_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/spt_cordic.sv]
// ----------------------------------------------------------------------------
// spt_cordic - iterative atan2 unit
// Vectoring CORDIC, one micro-rotation per cycle, result in Q3.13 radians.
// ----------------------------------------------------------------------------
module spt_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [spt_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [spt_pkg::CORDIC_W-1:0] x_in,
    output logic                                done,
    output logic signed [15:0]                  angle
);

    localparam int W  = spt_pkg::CORDIC_W;
    localparam int AW = spt_pkg::ANGLE_W;

    typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_FIN} cstate_t;

    cstate_t               state_reg;
    logic [4:0]            cnt_reg;
    logic signed [W-1:0]   x_reg, y_reg;
    logic signed [AW-1:0]  z_reg;
    logic                  zero_reg;
    logic                  done_reg;
    logic signed [15:0]    angle_reg;

    logic signed [W-1:0]   xs, ys;
    logic signed [AW-1:0]  step_ang, z_rnd;

    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign step_ang = AW'(spt_pkg::atan_q16(cnt_reg));
    assign z_rnd    = (z_reg + AW'(4)) >>> 3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                CS_IDLE:
                begin
                    if (go)
                    begin
                        zero_reg <= (x_in == '0) && (y_in == '0);
                        cnt_reg  <= '0;
                        if (x_in < 0)
                        begin
                            z_reg <= (y_in >= 0) ? AW'(spt_pkg::PI_Q16)
                                                 : -AW'(spt_pkg::PI_Q16);
                            x_reg <= -x_in;
                            y_reg <= -y_in;
                        end
                        else
                        begin
                            z_reg <= '0;
                            x_reg <= x_in;
                            y_reg <= y_in;
                        end
                        state_reg <= CS_RUN;
                    end
                end
                CS_RUN:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + step_ang;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - step_ang;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(spt_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= CS_FIN;
                    end
                end
                CS_FIN:
                begin
                    if (zero_reg)
                    begin
                        angle_reg <= '0;
                    end
                    else if (z_rnd > AW'(spt_pkg::PI_Q13))
                    begin
                        angle_reg <= 16'(spt_pkg::PI_Q13);
                    end
                    else if (z_rnd < -AW'(spt_pkg::PI_Q13))
                    begin
                        angle_reg <= -16'(spt_pkg::PI_Q13);
                    end
                    else
                    begin
                        angle_reg <= z_rnd[15:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= CS_IDLE;
                end
                default:
                begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

[rtl/stanley_path_tracking_steer.sv]
// ----------------------------------------------------------------------------
// stanley_path_tracking_steer - Stanley lateral path-tracking controller
// Path store, nearest-vertex scan, heading and cross-track error, steer law.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the beat is taken on a rising
//   edge where start is high and busy is low.
//   A load beat (operation = load) writes point_x/point_y into slot
//   point_index of the path store and gives no result; busy stays low,
//   so loads may follow back to back. Slots at or above PATH_DEPTH are
//   dropped.
//   A control beat raises busy until its result is out; a new control beat
//   is taken only once busy is low again. The nearest vertex scan uses the
//   one shared 32x32 multiplier for each of the first N stored points,
//   N = path_count clamped to 1..PATH_DEPTH; then two CORDIC runs and a
//   31-step square root follow (the root is skipped when the cross-track
//   distance saturates).
//   Result channel: result_valid pulses for one cycle with the result beat,
//   in the same cycle busy falls. The receiver cannot stall; take it then.
//   Configuration: cfg_write/cfg_index/cfg_data write a register at once;
//   write only while busy is low.
//   Reset: registers take their reset values, the sequencer goes idle.
//   The path store is not cleared; load every slot in use before control.
// ----------------------------------------------------------------------------
module stanley_path_tracking_steer #(
    parameter int PATH_DEPTH = spt_pkg::PATH_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  spt_pkg::in_item_t   item,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                result_valid,
    output spt_pkg::res_item_t  result
);

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int NW = AW + 1;
    localparam int CW = spt_pkg::CORDIC_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_X, ST_SCAN_Y, ST_SCAN_C,
        ST_FETCH_J, ST_FETCH_K, ST_DIFF, ST_ATAN_P, ST_SQRT,
        ST_CROSS1, ST_CROSS2, ST_GAIN, ST_ATAN_S
    } state_t;

    // configuration registers
    logic [15:0] gain_k_reg, soft_speed_reg;
    logic [13:0] steer_limit_reg;
    logic [9:0]  path_count_reg;

    state_t state_reg;

    // captured pose
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] psi_reg;
    logic [15:0]        speed_reg;

    // scan datapath
    logic [AW-1:0]      idx_reg, best_reg;
    logic signed [32:0] dx_reg, dy_reg, vx_reg, vy_reg;
    logic [63:0]        sx_reg, sy_reg;
    logic [64:0]        best_dist_reg;

    // path geometry
    logic signed [31:0] xj_reg, yj_reg;
    logic signed [32:0] dxp_reg, dyp_reg;
    logic signed [15:0] epsi_reg;

    // square root
    logic [61:0] v_reg, res_reg, bit_reg;
    logic [30:0] m_reg;

    // cross-product sign
    logic signed [65:0] s1_reg;
    logic               neg_reg;
    logic signed [31:0] ey_reg;

    logic               result_valid_reg;
    spt_pkg::res_item_t result_reg;

    // memory port
    logic [AW-1:0] raddr;
    logic [63:0]   rd_data;
    logic          ram_we;
    logic signed [31:0] rd_x, rd_y;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // CORDIC link
    logic                 cordic_go, cordic_done;
    logic signed [CW-1:0] cordic_y, cordic_x;
    logic signed [15:0]   cordic_angle;

    logic [NW-1:0]      n_eff;
    logic [AW-1:0]      last_idx, j_idx, k_idx;
    logic signed [32:0] dx_now, dy_now, dxp_now, dyp_now, dx_use;
    logic [64:0]        dist_sum;
    logic               take;
    logic [61:0]        trial;
    logic signed [18:0] e_raw, e_wrap, e_fix;
    logic signed [65:0] prod_signed;
    logic signed [17:0] delta, lim;
    logic [16:0]        speed_sum;
    logic [47:0]        gain_prod;

    assign rd_x = rd_data[63:32];
    assign rd_y = rd_data[31:0];

    // clamp the point count to 1..PATH_DEPTH
    always_comb
    begin
        if (path_count_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(path_count_reg) > PATH_DEPTH)
        begin
            n_eff = NW'(PATH_DEPTH);
        end
        else
        begin
            n_eff = NW'(path_count_reg);
        end
    end

    assign last_idx = AW'(n_eff - NW'(1));
    assign j_idx    = (best_reg == last_idx) ? last_idx : best_reg + AW'(1);
    assign k_idx    = (best_reg == '0) ? '0 : best_reg - AW'(1);

    always_comb
    begin
        unique case (state_reg)
            ST_SCAN_Y, ST_SCAN_C: raddr = idx_reg + AW'(1);
            ST_FETCH_J:           raddr = j_idx;
            ST_FETCH_K:           raddr = k_idx;
            default:              raddr = idx_reg;
        endcase
    end

    assign ram_we = start && !busy && (item.operation == spt_pkg::OP_LOAD)
                    && (32'(item.point_index) < PATH_DEPTH);

    spt_ram #(
        .WIDTH (64),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.point_index)),
        .wdata ({item.point_x, item.point_y}),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign dx_now  = {px_reg[31], px_reg} - {rd_x[31], rd_x};
    assign dy_now  = {py_reg[31], py_reg} - {rd_y[31], rd_y};
    assign dxp_now = {xj_reg[31], xj_reg} - {rd_x[31], rd_x};
    assign dyp_now = {yj_reg[31], yj_reg} - {rd_y[31], rd_y};
    assign dx_use  = ((dxp_reg == '0) && (dyp_reg == '0)) ? 33'sd1 : dxp_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_SCAN_X:
            begin
                mul_a = spt_pkg::mag33(dx_now);
                mul_b = spt_pkg::mag33(dx_now);
            end
            ST_SCAN_Y:
            begin
                mul_a = spt_pkg::mag33(dy_reg);
                mul_b = spt_pkg::mag33(dy_reg);
            end
            ST_CROSS1:
            begin
                mul_a = spt_pkg::mag33(dx_use);
                mul_b = spt_pkg::mag33(vy_reg);
            end
            ST_CROSS2:
            begin
                mul_a = spt_pkg::mag33(dyp_reg);
                mul_b = spt_pkg::mag33(vx_reg);
            end
            ST_GAIN:
            begin
                mul_a = 32'(gain_k_reg);
                mul_b = 32'(m_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dist_sum = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign take     = (idx_reg == '0) || (dist_sum < best_dist_reg);
    assign trial    = res_reg + bit_reg;

    // signed product for the cross-product compare; sign folds to zero
    always_comb
    begin
        logic a_neg, b_neg;
        a_neg = 1'b0;
        b_neg = 1'b0;
        if (state_reg == ST_CROSS1)
        begin
            a_neg = dx_use[32];
            b_neg = vy_reg[32];
        end
        else
        begin
            a_neg = dyp_reg[32];
            b_neg = vx_reg[32];
        end
        if ((a_neg != b_neg) && (mul_p != '0))
        begin
            prod_signed = -$signed({2'b00, mul_p});
        end
        else
        begin
            prod_signed = $signed({2'b00, mul_p});
        end
    end

    // heading error wrap to plus or minus pi
    assign e_raw = 19'(cordic_angle) - 19'(psi_reg) + 19'(spt_pkg::PI_Q13);
    always_comb
    begin
        if (e_raw < 0)
        begin
            e_wrap = e_raw + 19'(spt_pkg::TWO_PI_Q13);
        end
        else if (e_raw >= 19'(spt_pkg::TWO_PI_Q13))
        begin
            e_wrap = e_raw - 19'(spt_pkg::TWO_PI_Q13);
        end
        else
        begin
            e_wrap = e_raw;
        end
        e_fix = e_wrap - 19'(spt_pkg::PI_Q13);
    end

    assign gain_prod = mul_p[47:0];
    assign speed_sum = 17'(speed_reg) + 17'(soft_speed_reg);
    assign cordic_go = (state_reg == ST_DIFF) || (state_reg == ST_GAIN);

    always_comb
    begin
        if (state_reg == ST_GAIN)
        begin
            cordic_y = neg_reg ? -$signed(CW'(gain_prod)) : $signed(CW'(gain_prod));
            cordic_x = $signed(CW'({speed_sum, 16'd0}));
        end
        else
        begin
            cordic_y = CW'(dyp_now);
            cordic_x = CW'(dxp_now);
        end
    end

    spt_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cordic_go),
        .y_in  (cordic_y),
        .x_in  (cordic_x),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    assign delta = 18'(epsi_reg) + 18'(cordic_angle);
    assign lim   = $signed({4'b0000, steer_limit_reg});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_k_reg      <= spt_pkg::GAIN_K_RESET;
            soft_speed_reg  <= spt_pkg::SOFT_SPEED_RESET;
            steer_limit_reg <= spt_pkg::STEER_LIMIT_RESET;
            path_count_reg  <= spt_pkg::PATH_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                spt_pkg::CFG_GAIN_K:      gain_k_reg      <= cfg_data;
                spt_pkg::CFG_SOFT_SPEED:  soft_speed_reg  <= cfg_data;
                spt_pkg::CFG_STEER_LIMIT: steer_limit_reg <= cfg_data[13:0];
                spt_pkg::CFG_PATH_COUNT:  path_count_reg  <= cfg_data[9:0];
                default:                  ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            idx_reg          <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && (item.operation == spt_pkg::OP_CONTROL))
                    begin
                        px_reg    <= item.vehicle_x;
                        py_reg    <= item.vehicle_y;
                        psi_reg   <= item.vehicle_heading;
                        speed_reg <= item.vehicle_speed;
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_X;
                end
                ST_SCAN_X:
                begin
                    dx_reg    <= dx_now;
                    dy_reg    <= dy_now;
                    sx_reg    <= mul_p;
                    state_reg <= ST_SCAN_Y;
                end
                ST_SCAN_Y:
                begin
                    sy_reg    <= mul_p;
                    state_reg <= ST_SCAN_C;
                end
                ST_SCAN_C:
                begin
                    // strict compare: the first minimum holds
                    if (take)
                    begin
                        best_dist_reg <= dist_sum;
                        best_reg      <= idx_reg;
                        vx_reg        <= dx_reg;
                        vy_reg        <= dy_reg;
                    end
                    if (idx_reg == last_idx)
                    begin
                        state_reg <= ST_FETCH_J;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_SCAN_X;
                    end
                end
                ST_FETCH_J:
                begin
                    state_reg <= ST_FETCH_K;
                end
                ST_FETCH_K:
                begin
                    xj_reg    <= rd_x;
                    yj_reg    <= rd_y;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    dxp_reg   <= dxp_now;
                    dyp_reg   <= dyp_now;
                    state_reg <= ST_ATAN_P;
                end
                ST_ATAN_P:
                begin
                    if (cordic_done)
                    begin
                        epsi_reg <= e_fix[15:0];
                        if (best_dist_reg[64:62] != '0)
                        begin
                            m_reg     <= 31'h7FFF_FFFF;
                            state_reg <= ST_CROSS1;
                        end
                        else
                        begin
                            v_reg     <= best_dist_reg[61:0];
                            res_reg   <= '0;
                            bit_reg   <= 62'd1 << 60;
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT:
                begin
                    // one result bit per cycle
                    if (v_reg >= trial)
                    begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        m_reg     <= (v_reg >= trial) ? 31'((res_reg >> 1) + bit_reg)
                                                      : 31'(res_reg >> 1);
                        state_reg <= ST_CROSS1;
                    end
                end
                ST_CROSS1:
                begin
                    s1_reg    <= prod_signed;
                    state_reg <= ST_CROSS2;
                end
                ST_CROSS2:
                begin
                    neg_reg   <= s1_reg < prod_signed;
                    state_reg <= ST_GAIN;
                end
                ST_GAIN:
                begin
                    ey_reg    <= neg_reg ? -$signed({1'b0, m_reg}) : $signed({1'b0, m_reg});
                    state_reg <= ST_ATAN_S;
                end
                ST_ATAN_S:
                begin
                    if (cordic_done)
                    begin
                        if (delta > lim)
                        begin
                            result_reg.steer_angle <= lim[14:0];
                        end
                        else if (delta < -lim)
                        begin
                            result_reg.steer_angle <= 15'(-lim);
                        end
                        else
                        begin
                            result_reg.steer_angle <= delta[14:0];
                        end
                        result_reg.cross_track_error <= ey_reg;
                        result_reg.heading_error     <= epsi_reg;
                        result_reg.nearest_index     <= 9'(best_reg);
                        result_valid_reg             <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/spt_checker.sv]
// ----------------------------------------------------------------------------
// spt_port_checks - port-level checks for the Stanley steering block
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module spt_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input spt_pkg::in_item_t  item,
    input logic               result_valid
);

    // a result beat lasts one cycle
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beat longer than one cycle");

    // a load never makes the block busy
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.operation == spt_pkg::OP_LOAD)) |=> !busy)
        else $error("load beat raised busy");

    // a control beat holds busy
    a_ctrl_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.operation == spt_pkg::OP_CONTROL)) |=> busy)
        else $error("control beat did not raise busy");

    // busy drops exactly with the result beat
    a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy fell without a result beat");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

endmodule

bind stanley_path_tracking_steer spt_port_checks u_spt_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid)
);
